// ===== design/lrutc_pkg.sv =====
package lrutc_pkg;

    localparam int ENTRIES     = 8;
    localparam int KEY_BITS    = 64;
    localparam int DATA_BITS   = 32;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int KEY_TAG_W   = 64;
    localparam int DATA_WORD_W = 32;
    localparam int SLOT_W      = 3;
    localparam int DATA_OUT_W  = 32;
    localparam int STAMP_W     = 32;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

endpackage

// ===== design/lrutc_if.sv =====
interface lrutc_req_if import lrutc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [KEY_TAG_W-1:0]   key_tag;
    logic [DATA_WORD_W-1:0] data_word;

    modport source (output valid, output op, output key_tag, output data_word, input ready);
    modport sink   (input valid, input op, input key_tag, input data_word, output ready);
endinterface

interface lrutc_rsp_if import lrutc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [SLOT_W-1:0]     slot;
    logic [DATA_OUT_W-1:0] data_out;
    logic                  evicted;

    modport source (output valid, output hit, output slot, output data_out, output evicted,
                    input ready);
    modport sink   (input valid, input hit, input slot, input data_out, input evicted,
                    output ready);
endinterface

// ===== design/lru_tag_cache_table_top.sv =====
// Fully associative tag table with least-recently-used replacement.
// i_req carries one request per beat: op (lookup or insert), key_tag and
// data_word. o_rsp returns exactly one beat per request: hit, slot, data_out
// and evicted.
// One comparator pair (key equality and stamp less-than) walks the entries,
// one entry per cycle. A lookup stops at the first matching valid entry, an
// insert at the first empty entry; a full table is swept completely to find
// the oldest stamp. After the walk in S_SCAN, S_FIN registers the response;
// i_req.ready is low from acceptance until the response is registered, so a
// new request is taken only once the previous one has finished its walk.
// The response sits in an output register; a new request is accepted while
// it waits. If o_rsp.ready stays low, the next request completes its walk and
// holds until the register frees, with no loss and no reordering.
// Reset (synchronous, active low) empties the table, clears the stamps and
// the use counter, and drops any pending response. No clearing pass is run.
module lru_tag_cache_table_top import lrutc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrutc_req_if.sink   i_req,
    lrutc_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state                r_state;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [DATA_BITS-1:0]  r_data;
    logic                  r_hit;
    logic                  r_evict;
    logic [IDX_W-1:0]      r_pos;
    logic [STAMP_W-1:0]    r_best;
    logic [DATA_BITS-1:0]  r_dout;
    logic [STAMP_W-1:0]    r_counter;
    logic [ENTRIES-1:0]    r_valid;
    logic [STAMP_W-1:0]    r_stamp    [ENTRIES];
    logic [KEY_BITS-1:0]   r_key_mem  [ENTRIES];
    logic [DATA_BITS-1:0]  r_data_mem [ENTRIES];

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [SLOT_W-1:0]     r_out_slot;
    logic [DATA_OUT_W-1:0] r_out_dout;
    logic                  r_out_evict;

    logic                  n_accept;
    logic                  n_last;
    logic                  n_match;
    logic                  n_less;
    logic                  n_out_free;
    logic                  n_fin;
    logic                  n_write;
    logic [STAMP_W-1:0]    n_counter;

    assign i_req.ready  = (r_state == S_IDLE);
    assign n_accept     = i_req.valid && (r_state == S_IDLE);

    assign n_last       = (r_idx == IDX_W'(ENTRIES - 1));
    assign n_match      = r_valid[r_idx] && (r_key_mem[r_idx] == r_key);
    assign n_less       = (r_stamp[r_idx] < r_best);
    assign n_out_free   = !r_out_valid || o_rsp.ready;
    assign n_fin        = (r_state == S_FIN) && n_out_free;
    assign n_write      = n_fin && (r_op == OP_INSERT);
    assign n_counter    = (r_counter == STAMP_MAX) ? r_counter : r_counter + 1'b1;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.hit      = r_out_hit;
    assign o_rsp.slot     = r_out_slot;
    assign o_rsp.data_out = r_out_dout;
    assign o_rsp.evicted  = r_out_evict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_op        <= OP_LOOKUP;
            r_hit       <= 1'b0;
            r_evict     <= 1'b0;
            r_pos       <= '0;
            r_counter   <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_stamp[i] <= '0;
            end
        end else begin
            if (o_rsp.ready && !n_fin) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_op    <= i_req.op;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_evict <= 1'b0;
                        r_pos   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_op == OP_LOOKUP) begin
                        if (n_match) begin
                            r_hit   <= 1'b1;
                            r_pos   <= r_idx;
                            r_state <= S_FIN;
                        end else if (n_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        if (!r_valid[r_idx]) begin
                            r_pos   <= r_idx;
                            r_state <= S_FIN;
                        end else begin
                            // strict less-than keeps the lowest index on ties
                            if (r_idx == '0 || n_less) begin
                                r_pos <= r_idx;
                            end
                            if (n_last) begin
                                r_evict <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (n_out_free) begin
                        if (r_hit || (r_op == OP_INSERT)) begin
                            r_counter      <= n_counter;
                            r_stamp[r_pos] <= n_counter;
                        end
                        if (r_op == OP_INSERT) begin
                            r_valid[r_pos] <= 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_slot  <= SLOT_W'(r_pos);
                        r_out_dout  <= DATA_OUT_W'(r_dout);
                        r_out_evict <= r_evict;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: key and data store, request capture, lookup data, running minimum
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_key  <= i_req.key_tag[KEY_BITS-1:0];
            r_data <= DATA_BITS'(i_req.data_word);
            r_dout <= '0;
        end
        if ((r_state == S_SCAN) && (r_op == OP_LOOKUP) && n_match) begin
            r_dout <= r_data_mem[r_idx];
        end
        if ((r_state == S_SCAN) && (r_op == OP_INSERT) && (r_idx == '0 || n_less)) begin
            r_best <= r_stamp[r_idx];
        end
        if (n_write) begin
            r_key_mem[r_pos]  <= r_key;
            r_data_mem[r_pos] <= r_data;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lrutc_pkg::*;

    typedef struct packed {
        logic                   op;
        logic [KEY_TAG_W-1:0]   key;
        logic [DATA_WORD_W-1:0] data;
    } t_lru_req;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic [DATA_OUT_W-1:0] data_out;
        logic                  evicted;
    } t_lru_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   drv_valid = 1'b0;
    logic                   drv_op    = OP_LOOKUP;
    logic [KEY_TAG_W-1:0]   drv_key   = '0;
    logic [DATA_WORD_W-1:0] drv_data  = '0;
    logic                   rx_ready  = 1'b0;

    lrutc_req_if req_if ();
    lrutc_rsp_if rsp_if ();

    assign req_if.valid     = drv_valid;
    assign req_if.op        = drv_op;
    assign req_if.key_tag   = drv_key;
    assign req_if.data_word = drv_data;
    assign rsp_if.ready     = rx_ready;

    lru_tag_cache_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the tag table
    logic                 tbl_valid [ENTRIES];
    logic [KEY_BITS-1:0]  tbl_key   [ENTRIES];
    logic [DATA_BITS-1:0] tbl_data  [ENTRIES];
    logic [STAMP_W-1:0]   tbl_stamp [ENTRIES];
    logic [STAMP_W-1:0]   use_ctr;

    t_lru_req pending_req_q[$];
    t_lru_rsp expected_rsp_q[$];

    int err_count = 0;
    int rsp_count = 0;
    logic req_taken = 1'b0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_data[i]  = '0;
            tbl_stamp[i] = '0;
        end
        use_ctr = '0;
    end

    function automatic t_lru_rsp lru_predict(input t_lru_req rq);
        t_lru_rsp           r;
        int                 pos;
        logic [STAMP_W-1:0] best;
        r   = '0;
        pos = -1;
        if (rq.op == OP_LOOKUP) begin
            for (int i = 0; i < ENTRIES; i++)
                if (pos < 0 && tbl_valid[i] && tbl_key[i] == rq.key[KEY_BITS-1:0])
                    pos = i;
            if (pos >= 0) begin
                r.hit      = 1'b1;
                r.slot     = pos[SLOT_W-1:0];
                r.data_out = DATA_OUT_W'(tbl_data[pos]);
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (pos < 0 && !tbl_valid[i])
                    pos = i;
            if (pos < 0) begin
                // full table: oldest stamp goes, lowest index wins a tie
                pos  = 0;
                best = tbl_stamp[0];
                for (int i = 1; i < ENTRIES; i++)
                    if (tbl_stamp[i] < best) begin
                        best = tbl_stamp[i];
                        pos  = i;
                    end
                r.evicted = 1'b1;
            end
            tbl_valid[pos] = 1'b1;
            tbl_key[pos]   = rq.key[KEY_BITS-1:0];
            tbl_data[pos]  = rq.data[DATA_BITS-1:0];
            r.slot         = pos[SLOT_W-1:0];
        end
        if (pos >= 0) begin
            if (use_ctr != STAMP_MAX)
                use_ctr = use_ctr + 1'b1;
            tbl_stamp[pos] = use_ctr;
        end
        return r;
    endfunction

    task automatic add_req(input logic op, input logic [KEY_TAG_W-1:0] key,
                           input logic [DATA_WORD_W-1:0] data);
        t_lru_req rq;
        rq.op   = op;
        rq.key  = key;
        rq.data = data;
        pending_req_q.push_back(rq);
    endtask

    // Driver: bursts of beats separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_lru_req nxt;
        if (i_rst_n) begin
            if (drv_valid && !req_taken) begin
                // hold the beat until it is taken
            end else if (gap_left > 0) begin
                drv_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end else if (pending_req_q.size() > 0) begin
                nxt = pending_req_q.pop_front();
                drv_valid <= 1'b1;
                drv_op    <= nxt.op;
                drv_key   <= nxt.key;
                drv_data  <= nxt.data;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches periodically at random, plus one long hold-off
    int   rx_cycle     = 0;
    int   rx_mode      = 0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0)
            rx_mode <= $urandom_range(0, 3);
        if (holdoff_left > 0) begin
            rx_ready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && rsp_count >= 300) begin
            rx_ready     <= 1'b0;
            holdoff_left <= 400;
            holdoff_done <= 1'b1;
        end else begin
            case (rx_mode)
                0: rx_ready <= 1'b1;
                1: rx_ready <= 1'($urandom_range(0, 1));
                2: rx_ready <= (rx_cycle % 5 == 0);
                default: rx_ready <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // Monitor and predictor on the rising edge
    always @(posedge i_clk) begin
        t_lru_rsp exp_rsp;
        req_taken <= drv_valid && req_if.ready;
        if (i_rst_n) begin
            if (rsp_if.valid && rx_ready) begin
                rsp_count <= rsp_count + 1;
                if (expected_rsp_q.size() == 0) begin
                    $error("response beat with nothing expected");
                    err_count++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp_if.hit !== exp_rsp.hit) begin
                        $error("hit: expected %0d, got %0d", exp_rsp.hit, rsp_if.hit);
                        err_count++;
                    end
                    if (rsp_if.slot !== exp_rsp.slot) begin
                        $error("slot: expected %0d, got %0d", exp_rsp.slot, rsp_if.slot);
                        err_count++;
                    end
                    if (rsp_if.data_out !== exp_rsp.data_out) begin
                        $error("data_out: expected %h, got %h", exp_rsp.data_out,
                               rsp_if.data_out);
                        err_count++;
                    end
                    if (rsp_if.evicted !== exp_rsp.evicted) begin
                        $error("evicted: expected %0d, got %0d", exp_rsp.evicted,
                               rsp_if.evicted);
                        err_count++;
                    end
                end
            end
            if (drv_valid && req_if.ready)
                expected_rsp_q.push_back(lru_predict(t_lru_req'{drv_op, drv_key, drv_data}));
        end
    end

    logic [KEY_TAG_W-1:0] key_pool [10];

    initial begin
        int                     sel;
        logic [KEY_TAG_W-1:0]   k;
        logic [DATA_WORD_W-1:0] d;

        // Directed: empty table, extremes, duplicates, fill, eviction
        add_req(OP_LOOKUP, '0, '1);
        add_req(OP_INSERT, '0, '0);
        add_req(OP_INSERT, '1, '1);
        add_req(OP_LOOKUP, '1, '0);
        add_req(OP_LOOKUP, '0, 32'h1234_5678);
        add_req(OP_INSERT, '1, 32'hA5A5_A5A5);
        add_req(OP_LOOKUP, '1, '0);
        add_req(OP_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555);
        add_req(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        add_req(OP_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001);
        add_req(OP_INSERT, 64'h0000_0001_0000_0000, 32'h0000_0001);
        add_req(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 32'h7FFF_FFFF);
        add_req(OP_LOOKUP, 64'h5555_5555_5555_5555, '1);
        add_req(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE, '0);
        add_req(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF);
        add_req(OP_INSERT, 64'hFEDC_BA98_7654_3210, 32'hCAFE_F00D);
        add_req(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        add_req(OP_LOOKUP, '1, '0);
        add_req(OP_INSERT, 64'h0000_0000_0000_0002, '0);
        add_req(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '1);
        add_req(OP_LOOKUP, 64'h0000_0000_0000_0002, '0);
        add_req(OP_LOOKUP, 64'h1111_2222_3333_4444, '0);

        // Random: mostly a small pool of keys so that hits and evictions are common
        for (int i = 0; i < 10; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < 1100; n++) begin
            if (n % 150 == 149)
                for (int j = 0; j < 3; j++)
                    key_pool[$urandom_range(0, 9)] = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0: d = '0;
                1: d = '1;
                default: d = $urandom;
            endcase
            k   = key_pool[$urandom_range(0, 9)];
            sel = $urandom_range(0, 99);
            if (sel < 55)
                add_req(OP_LOOKUP, k, d);
            else if (sel < 85)
                add_req(OP_INSERT, k, d);
            else if (sel < 93)
                add_req(OP_LOOKUP, {$urandom, $urandom}, d);
            else
                add_req(OP_INSERT, {$urandom, $urandom}, d);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_req_q.size() != 0 || drv_valid)
            @(posedge i_clk);
        while (expected_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (err_count == 0 && expected_rsp_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
